FILE: src/lpc_pkg.sv
`default_nettype none
package lpc_pkg;

    // Fixed point format and loop limits
    localparam int FRAC_BITS = 16;
    localparam int AX_LIMIT  = 655360;

    // Field widths
    localparam int SIG_W   = 24;
    localparam int GAIN_W  = 24;
    localparam int LIM_W   = 23;
    localparam int DT_W    = 16;
    localparam int DEM_W   = 17;
    localparam int ERR_W   = 25;
    localparam int DIFF_W  = 26;
    localparam int INTEG_W = 40;
    localparam int DER_W   = 32;
    localparam int ACC_W   = 64;
    localparam int NUM_W   = DIFF_W + FRAC_BITS;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AX_KP       = 3'd0,
        REG_AX_KI       = 3'd1,
        REG_AX_KD       = 3'd2,
        REG_AX_KFF      = 3'd3,
        REG_AX_I_MAX    = 3'd4,
        REG_SPEED_KP    = 3'd5,
        REG_SPEED_KI    = 3'd6,
        REG_SPEED_I_MAX = 3'd7
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SP_INT,
        ST_SP_INT_W,
        ST_SP_P,
        ST_SP_P_W,
        ST_SP_I,
        ST_SP_I_W,
        ST_AX_E,
        ST_AX_INT,
        ST_AX_INT_W,
        ST_AX_DIV,
        ST_AX_DIV_W,
        ST_AX_P,
        ST_AX_P_W,
        ST_AX_I,
        ST_AX_I_W,
        ST_AX_D,
        ST_AX_D_W,
        ST_AX_F,
        ST_AX_F_W,
        ST_DONE
    } seq_state_t;

    // Serial multiplier control
    typedef struct packed {
        logic start;
        logic clear;
    } mul_cmd_t;

    // Integrator update: add the scaled increment, saturate, then clamp to limit if the gain is set
    function automatic logic signed [INTEG_W-1:0] integ_upd(
        input logic signed [INTEG_W-1:0] acc,
        input logic signed [ACC_W-1:0]   prod,
        input logic [GAIN_W-1:0]         ki,
        input logic [LIM_W-1:0]          lim
    );
        logic signed [ACC_W-1:0]   inc;
        logic signed [INTEG_W+1:0] sum;
        logic signed [INTEG_W+1:0] lim_x;
        logic signed [INTEG_W+1:0] imax_x;
        logic signed [INTEG_W+1:0] imin_x;
        logic signed [INTEG_W+1:0] r;
        inc    = prod >>> FRAC_BITS;
        imax_x = {3'b000, {(INTEG_W-1){1'b1}}};
        imin_x = {3'b111, {(INTEG_W-1){1'b0}}};
        lim_x  = {{(INTEG_W+2-LIM_W){1'b0}}, lim};
        sum    = (INTEG_W+2)'(acc) + inc[INTEG_W+1:0];
        if (sum > imax_x)
            r = imax_x;
        else if (sum < imin_x)
            r = imin_x;
        else
            r = sum;
        if (ki != '0)
        begin
            if (r > lim_x)
                r = lim_x;
            else if (r < -lim_x)
                r = -lim_x;
        end
        return r[INTEG_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: src/lpc_if.sv
`default_nettype none
interface lpc_in_if import lpc_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic signed [SIG_W-1:0]  target;
    logic signed [SIG_W-1:0]  measured_speed;
    logic signed [SIG_W-1:0]  measured_accel;
    logic [DT_W-1:0]          time_step;
    modport source (output valid, req_type, target, measured_speed, measured_accel,
                    time_step, input ready);
    modport sink (input valid, req_type, target, measured_speed, measured_accel,
                  time_step, output ready);
endinterface

interface lpc_out_if import lpc_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [DEM_W-1:0]         throttle;
    logic [DEM_W-1:0]         brake;
    logic signed [SIG_W-1:0]  accel_command;
    modport source (output valid, throttle, brake, accel_command, input ready);
    modport sink (input valid, throttle, brake, accel_command, output ready);
endinterface

interface lpc_cfg_if import lpc_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_W-1:0]     index;
    logic [GAIN_W-1:0]        data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: src/lpc_mul.sv
`default_nettype none
module lpc_mul import lpc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire mul_cmd_t                 cmd,
    input  wire logic [GAIN_W-1:0]        gain,
    input  wire logic signed [ACC_W-1:0]  opd,
    output logic signed [ACC_W-1:0]       acc,
    output logic                          done
);

    logic                     busy_reg;
    logic                     done_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic signed [ACC_W-1:0]  opd_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     last;

    // Finish once no set gain bits remain above the current one
    assign last = (gain_reg[GAIN_W-1:1] == '0);

    // Control: busy while gain bits remain, pulse done once the sum is final
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
                busy_reg <= 1'b1;
            else if (busy_reg && last)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath: one gain bit a cycle, shift-and-add into the accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            gain_reg <= gain;
            opd_reg  <= opd;
            if (cmd.clear)
                acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (gain_reg[0])
                acc_reg <= acc_reg + opd_reg;
            gain_reg <= gain_reg >> 1;
            opd_reg  <= opd_reg <<< 1;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

FILE: src/lpc_div.sv
`default_nettype none
module lpc_div import lpc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [NUM_W-1:0]   num,
    input  wire logic [DT_W-1:0]    den,
    output logic [NUM_W-1:0]        quo,
    output logic                    done
);

    localparam int CNT_W = $clog2(NUM_W);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [NUM_W-1:0]   q_reg;
    logic [DT_W-1:0]    rem_reg;
    logic [DT_W-1:0]    den_reg;
    logic [DT_W:0]      trial;
    logic               fits;

    // Restoring step: bring down one numerator bit, subtract if it fits
    assign trial = {rem_reg, q_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? DT_W'(trial - {1'b0, den_reg}) : trial[DT_W-1:0];
        end
    end

    assign quo  = q_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

FILE: src/longitudinal_pid_cascade_top.sv
// Longitudinal cascade controller: speed PI loop feeding an acceleration PID
// loop with feedforward, giving throttle and brake demands in unsigned Q1.16.
// Channels: "in" takes one control tick per item (req_type, target, measured
// speed and acceleration, time step); "out" returns one item per tick with
// throttle, brake and the acceleration command; "cfg" writes the eight gain
// and limit registers by index and is always ready.
// Every product runs through one shared shift-and-add multiplier, one gain
// bit per cycle; the derivative runs through a restoring divider at one
// quotient bit per cycle. The first tick skips the divider; a zero time step
// skips both loops and goes straight to the result. Products with small
// gains finish early. One tick is worked on at a time.
// Reset clears the state, output valid, configuration registers, both
// integrators and the stored error, and marks the next tick as the first sample.
// A finished result waits in the output register; the block takes the next
// item meanwhile, and holds its following result until the register is free.
`default_nettype none
module longitudinal_pid_cascade_top import lpc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    lpc_in_if.sink      in,
    lpc_out_if.source   out,
    lpc_cfg_if.sink     cfg
);

    localparam logic signed [ACC_W-1:0] AXL   = ACC_W'(AX_LIMIT);
    localparam logic signed [ACC_W-1:0] ONE_U = ACC_W'(1) <<< (2 * FRAC_BITS);
    localparam int                     OSH   = 2 * FRAC_BITS - 16;
    localparam logic [DEM_W-1:0]       FULL  = DEM_W'(65536);

    seq_state_t state_reg, state_next;

    // Configuration registers
    logic [GAIN_W-1:0] ax_kp_reg, ax_ki_reg, ax_kd_reg, ax_kff_reg;
    logic [GAIN_W-1:0] speed_kp_reg, speed_ki_reg;
    logic [LIM_W-1:0]  ax_i_max_reg, speed_i_max_reg;

    // Loop state
    logic signed [INTEG_W-1:0] ai_reg, si_reg;
    logic signed [ERR_W-1:0]   prev_reg;
    logic                      first_reg;

    // Per-tick working registers
    logic signed [SIG_W-1:0]   ameas_reg;
    logic [DT_W-1:0]           dt_reg;
    logic signed [ERR_W-1:0]   ev_reg, e_reg;
    logic signed [SIG_W-1:0]   cmd_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [DER_W-1:0]   d_reg;
    logic [DEM_W-1:0]          thr_res_reg, brk_res_reg;

    // Output register
    logic                      out_valid_reg;
    logic [DEM_W-1:0]          thr_reg, brk_reg;
    logic signed [SIG_W-1:0]   cmd_out_reg;

    // Shared units
    mul_cmd_t                  mcmd;
    logic [GAIN_W-1:0]         mgain;
    logic signed [ACC_W-1:0]   mopd;
    logic signed [ACC_W-1:0]   macc;
    logic                      mdone;
    logic                      dstart;
    logic [NUM_W-1:0]          dnum;
    logic [NUM_W-1:0]          dquo;
    logic                      ddone;
    logic [DIFF_W-1:0]         dmag;

    logic                      accept;
    logic                      out_free;
    logic signed [ACC_W-1:0]   sh_cmd;
    logic signed [ACC_W-1:0]   uneg;

    lpc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mcmd),
        .gain  (mgain),
        .opd   (mopd),
        .acc   (macc),
        .done  (mdone)
    );

    lpc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dstart),
        .num   (dnum),
        .den   (dt_reg),
        .quo   (dquo),
        .done  (ddone)
    );

    assign in.ready  = (state_reg == ST_IDLE);
    assign accept    = in.valid && in.ready;
    assign cfg.ready = 1'b1;
    assign out_free  = !out_valid_reg || out.ready;

    assign dmag   = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);
    assign dnum   = {dmag, {FRAC_BITS{1'b0}}};
    assign sh_cmd = macc >>> FRAC_BITS;
    assign uneg   = -macc;

    // Hold the state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Sequence the tick and drive the shared units
    always_comb
    begin
        state_next = state_reg;
        mcmd       = '0;
        mgain      = '0;
        mopd       = '0;
        dstart     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in.time_step == '0)
                        state_next = ST_DONE;
                    else if (in.req_type)
                        state_next = ST_SP_INT;
                    else
                        state_next = ST_AX_E;
                end
            end
            ST_SP_INT:
            begin
                mcmd       = '{start: 1'b1, clear: 1'b1};
                mgain      = GAIN_W'(dt_reg);
                mopd       = ACC_W'(ev_reg);
                state_next = ST_SP_INT_W;
            end
            ST_SP_INT_W: if (mdone) state_next = ST_SP_P;
            ST_SP_P:
            begin
                mcmd       = '{start: 1'b1, clear: 1'b1};
                mgain      = speed_kp_reg;
                mopd       = ACC_W'(ev_reg);
                state_next = ST_SP_P_W;
            end
            ST_SP_P_W: if (mdone) state_next = ST_SP_I;
            ST_SP_I:
            begin
                mcmd       = '{start: 1'b1, clear: 1'b0};
                mgain      = speed_ki_reg;
                mopd       = ACC_W'(si_reg);
                state_next = ST_SP_I_W;
            end
            ST_SP_I_W: if (mdone) state_next = ST_AX_E;
            ST_AX_E:   state_next = ST_AX_INT;
            ST_AX_INT:
            begin
                mcmd       = '{start: 1'b1, clear: 1'b1};
                mgain      = GAIN_W'(dt_reg);
                mopd       = ACC_W'(e_reg);
                state_next = ST_AX_INT_W;
            end
            ST_AX_INT_W:
            begin
                if (mdone)
                    state_next = first_reg ? ST_AX_P : ST_AX_DIV;
            end
            ST_AX_DIV:
            begin
                dstart     = 1'b1;
                state_next = ST_AX_DIV_W;
            end
            ST_AX_DIV_W: if (ddone) state_next = ST_AX_P;
            ST_AX_P:
            begin
                mcmd       = '{start: 1'b1, clear: 1'b1};
                mgain      = ax_kp_reg;
                mopd       = ACC_W'(e_reg);
                state_next = ST_AX_P_W;
            end
            ST_AX_P_W: if (mdone) state_next = ST_AX_I;
            ST_AX_I:
            begin
                mcmd       = '{start: 1'b1, clear: 1'b0};
                mgain      = ax_ki_reg;
                mopd       = ACC_W'(ai_reg);
                state_next = ST_AX_I_W;
            end
            ST_AX_I_W: if (mdone) state_next = ST_AX_D;
            ST_AX_D:
            begin
                mcmd       = '{start: 1'b1, clear: 1'b0};
                mgain      = ax_kd_reg;
                mopd       = ACC_W'(d_reg);
                state_next = ST_AX_D_W;
            end
            ST_AX_D_W: if (mdone) state_next = ST_AX_F;
            ST_AX_F:
            begin
                mcmd       = '{start: 1'b1, clear: 1'b0};
                mgain      = ax_kff_reg;
                mopd       = ACC_W'(cmd_reg);
                state_next = ST_AX_F_W;
            end
            ST_AX_F_W: if (mdone) state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_kp_reg       <= '0;
            ax_ki_reg       <= '0;
            ax_kd_reg       <= '0;
            ax_kff_reg      <= '0;
            ax_i_max_reg    <= '0;
            speed_kp_reg    <= '0;
            speed_ki_reg    <= '0;
            speed_i_max_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_AX_KP:       ax_kp_reg       <= cfg.data;
                REG_AX_KI:       ax_ki_reg       <= cfg.data;
                REG_AX_KD:       ax_kd_reg       <= cfg.data;
                REG_AX_KFF:      ax_kff_reg      <= cfg.data;
                REG_AX_I_MAX:    ax_i_max_reg    <= cfg.data[LIM_W-1:0];
                REG_SPEED_KP:    speed_kp_reg    <= cfg.data;
                REG_SPEED_KI:    speed_ki_reg    <= cfg.data;
                REG_SPEED_I_MAX: speed_i_max_reg <= cfg.data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Update loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ai_reg    <= '0;
            si_reg    <= '0;
            prev_reg  <= '0;
            first_reg <= 1'b1;
        end
        else
        begin
            if (state_reg == ST_SP_INT_W && mdone)
                si_reg <= integ_upd(si_reg, macc, speed_ki_reg, speed_i_max_reg);
            if (state_reg == ST_AX_INT_W && mdone)
            begin
                ai_reg    <= integ_upd(ai_reg, macc, ax_ki_reg, ax_i_max_reg);
                prev_reg  <= e_reg;
                first_reg <= 1'b0;
            end
        end
    end

    // Work registers of the current tick
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ameas_reg   <= in.measured_accel;
            dt_reg      <= in.time_step;
            ev_reg      <= ERR_W'(in.target) - ERR_W'(in.measured_speed);
            cmd_reg     <= (in.time_step == '0) ? '0 : in.target;
            thr_res_reg <= '0;
            brk_res_reg <= '0;
        end
        if (state_reg == ST_SP_I_W && mdone)
        begin
            if (sh_cmd > AXL)
                cmd_reg <= SIG_W'(AXL);
            else if (sh_cmd < -AXL)
                cmd_reg <= SIG_W'(-AXL);
            else
                cmd_reg <= sh_cmd[SIG_W-1:0];
        end
        if (state_reg == ST_AX_E)
            e_reg <= ERR_W'(cmd_reg) - ERR_W'(ameas_reg);
        if (state_reg == ST_AX_INT_W && mdone)
        begin
            diff_reg <= DIFF_W'(e_reg) - DIFF_W'(prev_reg);
            d_reg    <= '0;
        end
        // Sign the truncated quotient and saturate to 32 bits
        if (state_reg == ST_AX_DIV_W && ddone)
        begin
            if (diff_reg[DIFF_W-1])
            begin
                if (dquo > NUM_W'(64'h8000_0000))
                    d_reg <= {1'b1, {(DER_W-1){1'b0}}};
                else
                    d_reg <= DER_W'(-dquo[DER_W-1:0]);
            end
            else
            begin
                if (dquo > NUM_W'(64'h7FFF_FFFF))
                    d_reg <= {1'b0, {(DER_W-1){1'b1}}};
                else
                    d_reg <= dquo[DER_W-1:0];
            end
        end
        // Split the loop output into throttle and brake
        if (state_reg == ST_AX_F_W && mdone)
        begin
            if (!macc[ACC_W-1])
            begin
                thr_res_reg <= (macc > ONE_U) ? FULL : macc[OSH+DEM_W-1:OSH];
                brk_res_reg <= '0;
            end
            else
            begin
                thr_res_reg <= '0;
                brk_res_reg <= (uneg > ONE_U) ? FULL : uneg[OSH+DEM_W-1:OSH];
            end
        end
    end

    // Output register: load when free, drop valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_DONE && out_free)
            out_valid_reg <= 1'b1;
        else if (out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            thr_reg     <= thr_res_reg;
            brk_reg     <= brk_res_reg;
            cmd_out_reg <= cmd_reg;
        end
    end

    assign out.valid         = out_valid_reg;
    assign out.throttle      = thr_reg;
    assign out.brake         = brk_reg;
    assign out.accel_command = cmd_out_reg;

    // Multiplier results only arrive while a wait state expects them
    a_mul_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        mdone |-> (state_reg == ST_SP_INT_W || state_reg == ST_SP_P_W ||
                   state_reg == ST_SP_I_W || state_reg == ST_AX_INT_W ||
                   state_reg == ST_AX_P_W || state_reg == ST_AX_I_W ||
                   state_reg == ST_AX_D_W || state_reg == ST_AX_F_W))
        else $error("multiplier result outside a wait state");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        ddone |-> state_reg == ST_AX_DIV_W)
        else $error("divider result outside its wait state");

    a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(first_reg) |-> $past(state_reg) == ST_AX_INT_W)
        else $error("first sample cleared outside the integrator update");

    a_no_div_first: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_AX_DIV |-> !first_reg && $past(state_reg) == ST_AX_INT_W)
        else $error("derivative division on the first sample");

endmodule
`default_nettype wire

FILE: tb/lpc_checker.sv
module lpc_checker import lpc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    lpc_in_if           in,
    lpc_out_if          out,
    lpc_cfg_if          cfg,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [DEM_W-1:0]        throttle;
        logic [DEM_W-1:0]        brake;
        logic signed [SIG_W-1:0] accel_command;
    } demand_t;

    localparam longint SAT_HI = 64'sd549755813887;
    localparam longint SAT_LO = -64'sd549755813888;

    demand_t demand_q[$];

    longint g_ax_kp, g_ax_ki, g_ax_kd, g_ax_kff, g_ax_imax;
    longint g_sp_kp, g_sp_ki, g_sp_imax;
    longint acc_int, prev_err, sp_int;
    bit     first;

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Integrator step: floor-shifted increment, saturate, then clamp if gain set
    function automatic longint integrate(longint acc, longint e, longint dt,
                                         longint ki, longint lim);
        longint r;
        r = clip(acc + ((e * dt) >>> FRAC_BITS), SAT_LO, SAT_HI);
        if (ki != 0)
            r = clip(r, -lim, lim);
        return r;
    endfunction

    // Predict one tick and advance the controller state
    function automatic demand_t control_tick(logic mode, longint tgt, longint vm,
                                             longint am, longint dt);
        demand_t r;
        longint  cmd, e, d, u, one;
        one = longint'(1) << (2 * FRAC_BITS);
        r = '0;
        if (dt == 0)
            return r;
        if (mode)
        begin
            e = tgt - vm;
            sp_int = integrate(sp_int, e, dt, g_sp_ki, g_sp_imax);
            cmd = (g_sp_kp * e + g_sp_ki * sp_int) >>> FRAC_BITS;
            cmd = clip(cmd, -longint'(AX_LIMIT), longint'(AX_LIMIT));
        end
        else
            cmd = tgt;
        e = cmd - am;
        acc_int = integrate(acc_int, e, dt, g_ax_ki, g_ax_imax);
        d = 0;
        if (!first)
            d = clip(((e - prev_err) * 65536) / dt, -64'sd2147483648, 64'sd2147483647);
        prev_err = e;
        first = 0;
        u = g_ax_kp * e + g_ax_ki * acc_int + g_ax_kd * d + g_ax_kff * cmd;
        if (u >= 0)
            r.throttle = DEM_W'(clip(u, 0, one) >>> (2 * FRAC_BITS - 16));
        else
            r.brake = DEM_W'(clip(-u, 0, one) >>> (2 * FRAC_BITS - 16));
        r.accel_command = SIG_W'(cmd);
        return r;
    endfunction

    assign pending = demand_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        demand_t want;
        if (!rst_n)
        begin
            g_ax_kp = 0; g_ax_ki = 0; g_ax_kd = 0; g_ax_kff = 0; g_ax_imax = 0;
            g_sp_kp = 0; g_sp_ki = 0; g_sp_imax = 0;
            acc_int = 0; prev_err = 0; sp_int = 0; first = 1;
            fail_count <= 0;
            demand_q.delete();
        end
        else
        begin
            // Register writes
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_reg_t'(cfg.index))
                    REG_AX_KP:       g_ax_kp = longint'(cfg.data);
                    REG_AX_KI:       g_ax_ki = longint'(cfg.data);
                    REG_AX_KD:       g_ax_kd = longint'(cfg.data);
                    REG_AX_KFF:      g_ax_kff = longint'(cfg.data);
                    REG_AX_I_MAX:    g_ax_imax = longint'(cfg.data[LIM_W-1:0]);
                    REG_SPEED_KP:    g_sp_kp = longint'(cfg.data);
                    REG_SPEED_KI:    g_sp_ki = longint'(cfg.data);
                    REG_SPEED_I_MAX: g_sp_imax = longint'(cfg.data[LIM_W-1:0]);
                    default: ;
                endcase
            end
            // Compare results against the oldest prediction
            if (out.valid && out.ready)
            begin
                if (demand_q.size() == 0)
                begin
                    $error("unexpected result item");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = demand_q.pop_front();
                    if (out.throttle !== want.throttle ||
                        out.brake !== want.brake ||
                        out.accel_command !== want.accel_command)
                        fail_count <= fail_count + 1;
                    if (out.throttle !== want.throttle)
                        $error("throttle expected %0d actual %0d", want.throttle,
                               out.throttle);
                    if (out.brake !== want.brake)
                        $error("brake expected %0d actual %0d", want.brake, out.brake);
                    if (out.accel_command !== want.accel_command)
                        $error("accel_command expected %0d actual %0d",
                               want.accel_command, out.accel_command);
                end
            end
            // Predict accepted ticks
            if (in.valid && in.ready)
                demand_q.push_back(control_tick(in.req_type, longint'(in.target),
                    longint'(in.measured_speed), longint'(in.measured_accel),
                    longint'(in.time_step)));
        end
    end

endmodule

FILE: tb/testbench.sv
module testbench;
    import lpc_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    int   fail_count;
    int   pending;

    lpc_in_if  in_ch();
    lpc_out_if out_ch();
    lpc_cfg_if cfg_ch();

    longitudinal_pid_cascade_top dut (.clk(clk), .rst_n(rst_n), .in(in_ch),
                                      .out(out_ch), .cfg(cfg_ch));

    lpc_checker chk (.clk(clk), .rst_n(rst_n), .in(in_ch), .out(out_ch),
                     .cfg(cfg_ch), .fail_count(fail_count), .pending(pending));

    always #5 clk = ~clk;

    // Hard limit on run length
    initial
    begin
        #30000000;
        $display("Verification failed");
        $finish;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(0, 2);
        return $urandom_range(3, 60);
    endfunction

    // Receiver stalls
    initial
    begin
        int n;
        out_ch.ready = 0;
        forever
        begin
            @(negedge clk);
            if (out_ch.ready && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready = 0;
                n = gap_len();
                repeat (n) @(negedge clk);
                out_ch.ready = 1;
            end
            else
                out_ch.ready = 1;
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [GAIN_W-1:0] val);
        cfg_ch.valid = 1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 0;
    endtask

    task automatic send_tick(logic mode, logic [SIG_W-1:0] tgt, logic [SIG_W-1:0] vm,
                             logic [SIG_W-1:0] am, logic [DT_W-1:0] dt);
        int n;
        in_ch.valid = 1;
        in_ch.req_type = mode;
        in_ch.target = tgt;
        in_ch.measured_speed = vm;
        in_ch.measured_accel = am;
        in_ch.time_step = dt;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        n = gap_len();
        if ($urandom_range(0, 2) != 0)
            n = 0;
        if (n > 0)
        begin
            in_ch.valid = 0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Drain results, then allow the block to settle before a register write
    task automatic settle();
        in_ch.valid = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    // Load all eight registers with a gain class: all zero, all ones or random
    task automatic load_gains(int cls);
        logic [GAIN_W-1:0] g[8];
        for (int i = 0; i < 8; i++)
        begin
            case (cls)
                0: g[i] = '0;
                1: g[i] = '1;
                2: g[i] = GAIN_W'($urandom_range(0, 131072));
                default: g[i] = GAIN_W'($urandom);
            endcase
            if (cls == 2 && $urandom_range(0, 4) == 0)
                g[i] = '0;
            write_reg(cfg_reg_t'(i), g[i]);
        end
    endtask

    // Signal values mostly in a physical range, sometimes at extremes
    function automatic logic [SIG_W-1:0] sig_val();
        case ($urandom_range(0, 9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return SIG_W'($urandom);
            default: return SIG_W'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    function automatic logic [DT_W-1:0] dt_val();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return 16'hFFFF;
            2: return 16'd1;
            default: return DT_W'($urandom_range(200, 6000));
        endcase
    endfunction

    initial
    begin
        in_ch.valid = 0;
        in_ch.req_type = 0;
        in_ch.target = 0;
        in_ch.measured_speed = 0;
        in_ch.measured_accel = 0;
        in_ch.time_step = 0;
        cfg_ch.valid = 0;
        cfg_ch.index = REG_AX_KP;
        cfg_ch.data = 0;
        repeat (5) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: zero gains, zero step first, then extremes
        send_tick(0, 24'h7FFFFF, 0, 24'h800000, 0);
        send_tick(1, 24'h100000, 0, 0, 1000);
        settle();
        write_reg(REG_AX_KP, 24'h010000);
        write_reg(REG_AX_KI, 24'h000000);
        write_reg(REG_AX_KD, 24'h004000);
        write_reg(REG_AX_KFF, 24'h008000);
        write_reg(REG_AX_I_MAX, 24'h7FFFFF);
        write_reg(REG_SPEED_KP, 24'h020000);
        write_reg(REG_SPEED_KI, 24'h001000);
        write_reg(REG_SPEED_I_MAX, 24'h050000);
        send_tick(0, 24'h010000, 0, 0, 1000);
        send_tick(0, 24'hFF0000, 0, 0, 1000);
        send_tick(0, 24'h7FFFFF, 0, 24'h800000, 1);
        send_tick(0, 24'h800000, 0, 24'h7FFFFF, 1);
        send_tick(0, 24'h000100, 0, 0, 0);
        send_tick(1, 24'h7FFFFF, 24'h800000, 0, 16'hFFFF);
        send_tick(1, 24'h800000, 24'h7FFFFF, 0, 16'hFFFF);
        send_tick(1, 24'h050000, 24'h040000, 24'h001000, 2000);
        send_tick(1, 24'h030000, 24'h040000, 24'hFFF000, 2000);
        settle();
        load_gains(1);
        send_tick(1, 24'h7FFFFF, 24'h800000, 24'h800000, 16'hFFFF);
        send_tick(0, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF);
        send_tick(0, 24'h7FFFFF, 0, 24'h800000, 1);
        send_tick(1, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 1);
        settle();

        // Random phases across gain classes
        for (int ph = 0; ph < 9; ph++)
        begin
            load_gains(ph == 0 ? 0 : (ph == 4 ? 1 : (ph % 3 == 0 ? 3 : 2)));
            for (int k = 0; k < 147; k++)
                send_tick($urandom_range(0, 1), sig_val(), sig_val(), sig_val(), dt_val());
            settle();
        end

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
src/lpc_pkg.sv
src/lpc_if.sv
src/lpc_mul.sv
src/lpc_div.sv
src/longitudinal_pid_cascade_top.sv
tb/lpc_checker.sv
tb/testbench.sv
